### rtl/cpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared widths, prefix codes, table pages and decode phases for the
// opcode prefix decoder.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int CODE_W  = 8;
    localparam int PAGE_W  = 4;
    localparam int INDEX_W = PAGE_W + CODE_W;
    localparam int LEN_W   = 2;

    // prefix byte values
    localparam logic [CODE_W-1:0] PFX_IX = 8'hDD;
    localparam logic [CODE_W-1:0] PFX_IY = 8'hFD;
    localparam logic [CODE_W-1:0] PFX_ED = 8'hED;
    localparam logic [CODE_W-1:0] PFX_CB = 8'hCB;

    // instruction table pages of 256 entries: index = {page, opcode}
    localparam logic [PAGE_W-1:0] PAGE_PLAIN  = 4'd0;
    localparam logic [PAGE_W-1:0] PAGE_IX     = 4'd1;
    localparam logic [PAGE_W-1:0] PAGE_ED     = 4'd3;
    localparam logic [PAGE_W-1:0] PAGE_CB     = 4'd4;
    localparam logic [PAGE_W-1:0] PAGE_LONG   = 4'd5;
    localparam logic [PAGE_W-1:0] PAGE_IX_BIT = 4'd9;

    localparam logic [LEN_W-1:0] LEN_PLAIN  = 2'd1;
    localparam logic [LEN_W-1:0] LEN_PREFIX = 2'd2;
    localparam logic [LEN_W-1:0] LEN_LONG   = 2'd3;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_INDEX     = 6'b000010,
        PH_ED        = 6'b000100,
        PH_CB        = 6'b001000,
        PH_WAIT_DISP = 6'b010000,
        PH_WAIT_OP   = 6'b100000
    } phase_t;

endpackage

### rtl/cpd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_stream_if
// Valid/ready channels for code bytes in and decoded opcodes out.
// ----------------------------------------------------------------------------
interface cpd_byte_if;
    import cpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface cpd_result_if;
    import cpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] table_index;
    logic [LEN_W-1:0]   opcode_length;
    logic               has_displacement;
    logic [CODE_W-1:0]  displacement;

    modport source (output valid, output table_index, output opcode_length,
                    output has_displacement, output displacement, input ready);
    modport sink   (input valid, input table_index, input opcode_length,
                    input has_displacement, input displacement, output ready);
endinterface

### rtl/cpu_opcode_prefix_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_opcode_prefix_decoder
// Tracks DD/FD/ED/CB prefixes in a byte stream and emits one decoded opcode
// item per complete instruction opcode.
// ----------------------------------------------------------------------------
// an accepted opcode byte is held in the input register, then decoded into the result register
// throughput: one byte per cycle; the input register and the result register
//   each move on every cycle that the result side is not stalled
// prefix and displacement bytes produce no result item
// reset: asynchronous, active low; clears valids, decode phase, index select
//   and the saved displacement
module cpu_opcode_prefix_decoder (
    input  logic                clk,
    input  logic                rst_n,
    cpd_byte_if.sink            code,
    cpd_result_if.source        result
);
    import cpd_pkg::*;

    logic               s1_valid_reg;
    logic [CODE_W-1:0]  s1_byte_reg;

    phase_t             phase_reg, phase_next;
    logic               sel_reg, sel_next;
    logic [CODE_W-1:0]  disp_reg, disp_next;

    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_has_disp_reg, out_has_disp_next;
    logic [CODE_W-1:0]  out_disp_reg, out_disp_next;

    logic               advance;
    logic               emit;
    logic [PAGE_W-1:0]  page;
    logic [PAGE_W-1:0]  sel_ext;
    logic               is_index_pfx;

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign code.ready = !s1_valid_reg || advance;

    assign sel_ext      = {{(PAGE_W-1){1'b0}}, sel_reg};
    assign is_index_pfx = (s1_byte_reg == PFX_IX) || (s1_byte_reg == PFX_IY);

    always_comb
    begin
        phase_next        = phase_reg;
        sel_next          = sel_reg;
        disp_next         = disp_reg;
        emit              = 1'b0;
        page              = PAGE_PLAIN;
        out_has_disp_next = 1'b0;
        case (phase_reg)
            PH_INDEX:
            begin
                if (is_index_pfx)
                begin
                    // last index prefix wins
                    sel_next = (s1_byte_reg == PFX_IY);
                end
                else if (s1_byte_reg == PFX_ED)
                begin
                    phase_next = PH_ED;
                end
                else if (s1_byte_reg == PFX_CB)
                begin
                    phase_next = PH_WAIT_DISP;
                end
                else
                begin
                    emit = 1'b1;
                    page = PAGE_IX + sel_ext;
                end
            end
            PH_ED:
            begin
                emit = 1'b1;
                page = PAGE_ED;
            end
            PH_CB:
            begin
                emit = 1'b1;
                page = PAGE_CB;
            end
            PH_WAIT_DISP:
            begin
                disp_next  = s1_byte_reg;
                phase_next = PH_WAIT_OP;
            end
            PH_WAIT_OP:
            begin
                emit              = 1'b1;
                page              = PAGE_IX_BIT + sel_ext;
                out_has_disp_next = 1'b1;
            end
            default:
            begin
                if (is_index_pfx)
                begin
                    sel_next   = (s1_byte_reg == PFX_IY);
                    phase_next = PH_INDEX;
                end
                else if (s1_byte_reg == PFX_ED)
                begin
                    phase_next = PH_ED;
                end
                else if (s1_byte_reg == PFX_CB)
                begin
                    phase_next = PH_CB;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
        endcase
        if (emit)
        begin
            phase_next = PH_IDLE;
        end
        out_index_next = {page, s1_byte_reg};
        if (page >= PAGE_LONG)
            out_len_next = LEN_LONG;
        else if (page != PAGE_PLAIN)
            out_len_next = LEN_PREFIX;
        else
            out_len_next = LEN_PLAIN;
        out_disp_next = out_has_disp_next ? disp_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            sel_reg       <= 1'b0;
            disp_reg      <= '0;
        end
        else
        begin
            if (code.ready)
            begin
                s1_valid_reg <= code.valid;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                sel_reg   <= sel_next;
                disp_reg  <= disp_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (code.valid && code.ready)
        begin
            s1_byte_reg <= code.code_byte;
        end
        if (advance && emit)
        begin
            out_index_reg    <= out_index_next;
            out_len_reg      <= out_len_next;
            out_has_disp_reg <= out_has_disp_next;
            out_disp_reg     <= out_disp_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.table_index      = out_index_reg;
    assign result.opcode_length    = out_len_reg;
    assign result.has_displacement = out_has_disp_reg;
    assign result.displacement     = out_disp_reg;

endmodule

### rtl/cpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks for the opcode prefix decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cpd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cpd_pkg::INDEX_W-1:0]  table_index,
    input logic [cpd_pkg::LEN_W-1:0]    opcode_length,
    input logic                         has_displacement,
    input logic [cpd_pkg::CODE_W-1:0]   displacement
);
    import cpd_pkg::*;

    // length 3 goes with a displacement, a missing displacement reads zero
    a_disp_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((opcode_length == LEN_LONG) == has_displacement)
                      && (has_displacement || displacement == '0))
        else $error("displacement fields disagree with opcode length");

    // opcode length follows the table page
    a_len_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((opcode_length == LEN_PLAIN) && (table_index[INDEX_W-1:CODE_W] == PAGE_PLAIN))
         || ((opcode_length == LEN_PREFIX) && (table_index[INDEX_W-1:CODE_W] != PAGE_PLAIN)
             && (table_index[INDEX_W-1:CODE_W] < PAGE_LONG))
         || ((opcode_length == LEN_LONG) && (table_index[INDEX_W-1:CODE_W] >= PAGE_LONG)))
        else $error("opcode length does not match table index");

    // a fresh result comes from an accepted byte that passed the input register and the result register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an accepted byte");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(table_index)
            && $stable(opcode_length) && $stable(displacement))
        else $error("stalled result item changed");

endmodule

bind cpu_opcode_prefix_decoder cpd_checker u_cpd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (code.valid),
    .in_ready         (code.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .table_index      (result.table_index),
    .opcode_length    (result.opcode_length),
    .has_displacement (result.has_displacement),
    .displacement     (result.displacement)
);
